// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the handle table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that a condition excludes another one in the same cycle.
`define ASSERT_NEVER_BOTH(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !((a) && (b))) else $error(msg);

`endif

// ===== rtl/ght_pkg.sv =====
// Types and constants of the generational handle table.
package ght_pkg;

	localparam int SLOT_W   = 16;
	localparam int GEN_W    = 32;
	localparam int HANDLE_W = 48;

	localparam logic [GEN_W-1:0] GEN_MAX = 32'hffff_ffff;

	// Operation codes.
	localparam logic [2:0] FN_INSTALL   = 3'd0;
	localparam logic [2:0] FN_UNINSTALL = 3'd1;
	localparam logic [2:0] FN_LAUNCH    = 3'd2;
	localparam logic [2:0] FN_PAUSE     = 3'd3;
	localparam logic [2:0] FN_RESUME    = 3'd4;
	localparam logic [2:0] FN_STOP      = 3'd5;

	// Application run states.
	localparam logic [1:0] RS_RUNNING = 2'd0;
	localparam logic [1:0] RS_PAUSED  = 2'd1;
	localparam logic [1:0] RS_STOPPED = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} seq_state_t;

	// Command to one slot table.
	typedef struct packed {
		logic rd;       // read the generation memory this cycle
		logic by_free;  // read at the first free slot instead of the given index
		logic alloc;    // claim the slot read last
		logic clear;    // release the slot read last
	} tbl_cmd_t;

	// Answer of one slot table, valid the cycle after a read.
	typedef struct packed {
		logic             found;
		logic             used;
		logic [GEN_W-1:0] gen;
		logic [GEN_W-1:0] gen_inc;
	} tbl_rsp_t;

endpackage

// ===== rtl/ght_slot_table.sv =====
// One slot table: used and exhausted bits, generation memory and free-slot search.
`include "assert_macros.svh"

module ght_slot_table #(
	parameter int SLOTS = 16,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ght_pkg::tbl_cmd_t cmd,
	input  logic [IW-1:0]    rd_idx,
	output logic [IW-1:0]    addr_s1,
	output ght_pkg::tbl_rsp_t rsp
);
	import ght_pkg::*;

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] exh_q;
	logic [SLOTS-1:0] gen_vld_q;
	logic [SLOTS-1:0] avail;
	logic [IW-1:0]    free_idx;
	logic             free_any;
	logic [IW-1:0]    rd_addr;
	logic             found_s1;
	logic             gen_vld_s1;
	logic [GEN_W-1:0] gen_rd_s1;
	logic [GEN_W-1:0] gen_mem [SLOTS];

	// Lowest slot that is neither in use nor worn out.
	assign avail = ~used_q & ~exh_q;

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign rd_addr = cmd.by_free ? free_idx : rd_idx;

	// Generation memory: one read port, one write port, registered read data.
	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			gen_mem[addr_s1] <= rsp.gen_inc;
		end
		if (cmd.rd) begin
			gen_rd_s1 <= gen_mem[rd_addr];
			addr_s1   <= rd_addr;
		end
	end

	// Per-slot flags and the read-side status that goes with the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			exh_q      <= '0;
			gen_vld_q  <= '0;
			found_s1   <= 1'b0;
			gen_vld_s1 <= 1'b0;
		end else begin
			if (cmd.rd) begin
				found_s1   <= free_any;
				gen_vld_s1 <= gen_vld_q[rd_addr];
			end
			if (cmd.alloc) begin
				used_q[addr_s1]    <= 1'b1;
				gen_vld_q[addr_s1] <= 1'b1;
				exh_q[addr_s1]     <= (rsp.gen_inc == GEN_MAX);
			end else if (cmd.clear) begin
				used_q[addr_s1] <= 1'b0;
			end
		end
	end

	// A slot never written still holds its reset generation of zero.
	always_comb begin
		rsp.found   = found_s1;
		rsp.used    = used_q[addr_s1];
		rsp.gen     = gen_vld_s1 ? gen_rd_s1 : '0;
		rsp.gen_inc = rsp.gen + GEN_W'(1);
	end

	`ASSERT_CLK(a_alloc_found, cmd.alloc |-> (rsp.found && !rsp.used), "allocation of a busy slot")
	`ASSERT_NEVER_BOTH(a_alloc_clear, cmd.alloc, cmd.clear, "slot claimed and released at once")
	`ASSERT_CLK(a_update_after_read, (cmd.alloc || cmd.clear) |-> !cmd.rd, "update overlaps a read")

endmodule

// ===== rtl/generational_handle_table_top.sv =====
// Top level of the generational handle table: sequencer, decode and result register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | func, handle, owner_task
//  out     | out_valid / out_stall| status, new_handle, app_state_after
//
// Each request is accepted in ST_IDLE, where it reads the generation memories
// that its operation needs; in ST_EXEC it checks the handle, writes back and loads
// the result register. The single memory read of each table sets this split.
// While a result waits under out_stall the next request is still accepted, but
// its ST_EXEC step waits until the result register is free.
// Reset clears all used bits and generations at once; no clearing pass.
`include "assert_macros.svh"

module generational_handle_table_top #(
	parameter int PKG_SLOTS = 16,
	parameter int APP_SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 func,
	input  logic [ght_pkg::HANDLE_W-1:0] handle,
	input  logic [63:0]                owner_task,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [ght_pkg::HANDLE_W-1:0] new_handle,
	output logic [1:0]                 app_state_after
);
	import ght_pkg::*;

	localparam int PIW = (PKG_SLOTS > 1) ? $clog2(PKG_SLOTS) : 1;
	localparam int AIW = (APP_SLOTS > 1) ? $clog2(APP_SLOTS) : 1;

	seq_state_t st_q;

	logic              accept;
	logic              fire;
	logic [SLOT_W-1:0] slot_num;
	logic [SLOT_W-1:0] slot_m1;

	logic [2:0]        func_s1;
	logic [GEN_W-1:0]  hgen_s1;
	logic              pkg_ok_s1;
	logic              app_ok_s1;
	logic              owner_nz_s1;

	tbl_cmd_t          pkg_cmd;
	tbl_cmd_t          app_cmd;
	tbl_rsp_t          pkg_rsp;
	tbl_rsp_t          app_rsp;
	logic [PIW-1:0]    pkg_addr_s1;
	logic [AIW-1:0]    app_addr_s1;

	logic              pkg_hit;
	logic              app_hit;
	logic              ok;
	logic              pkg_alloc;
	logic              pkg_clear;
	logic              app_alloc;
	logic              app_clear;
	logic [HANDLE_W-1:0] nh;
	logic [1:0]        rs;

	logic                out_valid_q;
	logic                status_q;
	logic [HANDLE_W-1:0] new_handle_q;
	logic [1:0]          state_after_q;

	// A request enters only when the sequencer is free.
	assign in_stall = (st_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fire     = (st_q == ST_EXEC) && (!out_valid_q || !out_stall);

	assign slot_num = handle[SLOT_W-1:0];
	assign slot_m1  = slot_num - SLOT_W'(1);

	// Table reads on accept, updates when the result is committed.
	always_comb begin
		pkg_cmd.rd      = accept && (func == FN_INSTALL || func == FN_UNINSTALL ||
		                             func == FN_LAUNCH);
		pkg_cmd.by_free = (func == FN_INSTALL);
		pkg_cmd.alloc   = fire && pkg_alloc;
		pkg_cmd.clear   = fire && pkg_clear;
		app_cmd.rd      = accept && (func == FN_LAUNCH || func == FN_PAUSE ||
		                             func == FN_RESUME || func == FN_STOP);
		app_cmd.by_free = (func == FN_LAUNCH);
		app_cmd.alloc   = fire && app_alloc;
		app_cmd.clear   = fire && app_clear;
	end

	ght_slot_table #(.SLOTS(PKG_SLOTS)) u_pkg_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (pkg_cmd),
		.rd_idx  (slot_m1[PIW-1:0]),
		.addr_s1 (pkg_addr_s1),
		.rsp     (pkg_rsp)
	);

	ght_slot_table #(.SLOTS(APP_SLOTS)) u_app_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (app_cmd),
		.rd_idx  (slot_m1[AIW-1:0]),
		.addr_s1 (app_addr_s1),
		.rsp     (app_rsp)
	);

	// Request fields held for the ST_EXEC state.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func;
			hgen_s1     <= handle[HANDLE_W-1:SLOT_W];
			pkg_ok_s1   <= (slot_num != '0) && (slot_num <= SLOT_W'(PKG_SLOTS));
			app_ok_s1   <= (slot_num != '0) && (slot_num <= SLOT_W'(APP_SLOTS));
			owner_nz_s1 <= (owner_task != '0);
		end
	end

	// Handle checks against the stored slot state.
	assign pkg_hit = pkg_ok_s1 && (hgen_s1 != '0) && pkg_rsp.used && (pkg_rsp.gen == hgen_s1);
	assign app_hit = app_ok_s1 && (hgen_s1 != '0) && app_rsp.used && (app_rsp.gen == hgen_s1);

	// Outcome of the operation.
	always_comb begin
		ok        = 1'b0;
		pkg_alloc = 1'b0;
		pkg_clear = 1'b0;
		app_alloc = 1'b0;
		app_clear = 1'b0;
		nh        = '0;
		rs        = RS_RUNNING;
		unique case (func_s1)
			FN_INSTALL: begin
				ok        = pkg_rsp.found;
				pkg_alloc = pkg_rsp.found;
				nh        = {pkg_rsp.gen_inc, SLOT_W'(pkg_addr_s1) + SLOT_W'(1)};
			end
			FN_UNINSTALL: begin
				ok        = pkg_hit;
				pkg_clear = pkg_hit;
			end
			FN_LAUNCH: begin
				ok        = owner_nz_s1 && pkg_hit && app_rsp.found;
				app_alloc = ok;
				nh        = {app_rsp.gen_inc, SLOT_W'(app_addr_s1) + SLOT_W'(1)};
				rs        = RS_RUNNING;
			end
			FN_PAUSE: begin
				ok = app_hit;
				rs = RS_PAUSED;
			end
			FN_RESUME: begin
				ok = app_hit;
				rs = RS_RUNNING;
			end
			FN_STOP: begin
				ok        = app_hit;
				app_clear = app_hit;
				rs        = RS_STOPPED;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= !ok;
			new_handle_q  <= ok ? nh : '0;
			state_after_q <= ok ? rs : RS_RUNNING;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign new_handle      = new_handle_q;
	assign app_state_after = state_after_q;

	`ASSERT_CLK(a_accept_exec, accept |=> (st_q == ST_EXEC), "accepted request did not start")
	`ASSERT_CLK(a_load_from_exec, $rose(out_valid_q) |-> $past(st_q == ST_EXEC), "result without request")
	`ASSERT_CLK(a_handle_success, (fire && !ok) |=> (new_handle_q == '0), "failed request returned a handle")

endmodule

// ===== tb/sv/tb_generational_handle_table_top.sv =====
// Self-checking testbench for the generational handle table top level.
`timescale 1ns / 1ps

module tb_generational_handle_table_top;
	import ght_pkg::*;

	localparam int NUM_SLOTS      = 16;
	localparam int TBL_PKG        = 0;
	localparam int TBL_APP        = 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	// Operation codes that the block does not decode.
	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;

	// Result status codes.
	localparam logic RES_OK   = 1'b0;
	localparam logic RES_FAIL = 1'b1;

	typedef struct packed {
		logic                status;
		logic [HANDLE_W-1:0] new_handle;
		logic [1:0]          state_after;
	} ght_result_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [2:0]          func       = FN_INSTALL;
	logic [HANDLE_W-1:0] handle     = '0;
	logic [63:0]         owner_task = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic                status;
	logic [HANDLE_W-1:0] new_handle;
	logic [1:0]          app_state_after;

	// Shadow copy of both slot tables, index TBL_PKG or TBL_APP.
	logic                slot_used [2][NUM_SLOTS];
	logic [GEN_W-1:0]    slot_gen  [2][NUM_SLOTS];

	ght_result_t         expected_results[$];
	ght_result_t         last_outcome;
	ght_result_t         next_expected;
	int unsigned         n_errors    = 0;
	int unsigned         idle_cycles = 0;
	int unsigned         stall_hold  = 0;
	bit                  quiet_mode  = 1'b0;

	generational_handle_table_top #(
		.PKG_SLOTS(NUM_SLOTS),
		.APP_SLOTS(NUM_SLOTS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.handle         (handle),
		.owner_task     (owner_task),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.new_handle     (new_handle),
		.app_state_after(app_state_after)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic [HANDLE_W-1:0] make_handle(input logic [GEN_W-1:0] gen, input int idx);
		return {gen, SLOT_W'(idx + 1)};
	endfunction

	// Index of the live slot a handle names, or -1 if the handle is not valid.
	function automatic int find_live(input int tbl, input logic [HANDLE_W-1:0] h);
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
		slot = h[SLOT_W-1:0];
		gen  = h[HANDLE_W-1:SLOT_W];
		if (slot == 0 || slot > NUM_SLOTS || gen == 0) return -1;
		if (!slot_used[tbl][slot-1] || slot_gen[tbl][slot-1] != gen) return -1;
		return int'(slot) - 1;
	endfunction

	// Claims the lowest free slot that is not exhausted; -1 when the table is full.
	function automatic int claim_slot(input int tbl);
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (!slot_used[tbl][i] && slot_gen[tbl][i] != GEN_MAX) begin
				slot_gen[tbl][i]  = slot_gen[tbl][i] + 1;
				slot_used[tbl][i] = 1'b1;
				return i;
			end
		end
		return -1;
	endfunction

	// Works out the result of one request and updates the shadow tables.
	function automatic ght_result_t predict_outcome(input logic [2:0] f,
			input logic [HANDLE_W-1:0] h, input logic [63:0] o);
		ght_result_t r;
		int          idx;
		r        = '0;
		r.status = RES_FAIL;
		case (f)
			FN_INSTALL: begin
				idx = claim_slot(TBL_PKG);
				if (idx >= 0) begin
					r.status     = RES_OK;
					r.new_handle = make_handle(slot_gen[TBL_PKG][idx], idx);
				end
			end
			FN_UNINSTALL: begin
				idx = find_live(TBL_PKG, h);
				if (idx >= 0) begin
					slot_used[TBL_PKG][idx] = 1'b0;
					r.status = RES_OK;
				end
			end
			FN_LAUNCH: begin
				// A zero owner fails before the package handle is looked at.
				if (o != 0 && find_live(TBL_PKG, h) >= 0) begin
					idx = claim_slot(TBL_APP);
					if (idx >= 0) begin
						r.status      = RES_OK;
						r.new_handle  = make_handle(slot_gen[TBL_APP][idx], idx);
						r.state_after = RS_RUNNING;
					end
				end
			end
			FN_PAUSE, FN_RESUME, FN_STOP: begin
				idx = find_live(TBL_APP, h);
				if (idx >= 0) begin
					r.status = RES_OK;
					if (f == FN_PAUSE) begin
						r.state_after = RS_PAUSED;
					end else if (f == FN_RESUME) begin
						r.state_after = RS_RUNNING;
					end else begin
						r.state_after = RS_STOPPED;
						slot_used[TBL_APP][idx] = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Mostly live handles, then stale or freed ones, then corner and random values.
	function automatic logic [HANDLE_W-1:0] pick_handle(input int tbl);
		int live[$];
		int i;
		int idx;
		int unsigned r;
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (slot_used[tbl][i]) live.push_back(i);
		end
		r = $urandom_range(0, 99);
		if (r < 75 && live.size() != 0) begin
			idx = live[$urandom_range(0, live.size() - 1)];
			return make_handle(slot_gen[tbl][idx], idx);
		end
		if (r < 87) begin
			idx = $urandom_range(0, NUM_SLOTS - 1);
			return make_handle(slot_gen[tbl][idx] - GEN_W'($urandom_range(0, 1)), idx);
		end
		if (r < 93) return {GEN_W'($urandom()), SLOT_W'($urandom_range(0, NUM_SLOTS + 1))};
		return {SLOT_W'($urandom()), $urandom()};
	endfunction

	// Offers one request after a random gap, none in quiet mode, and records its expected result once taken.
	task automatic send_request(input logic [2:0] f, input logic [HANDLE_W-1:0] h,
			input logic [63:0] o);
		int unsigned gap;
		gap = quiet_mode ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		handle     <= h;
		owner_task <= o;
		do @(posedge clk); while (in_stall);
		last_outcome = predict_outcome(f, h, o);
		expected_results.push_back(last_outcome);
	endtask

	// Holds the sender back until every outstanding result has come out.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [HANDLE_W-1:0] want,
			input logic [HANDLE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			n_errors++;
		end
	endtask

	// Undecoded operations with the extremes of both data fields.
	task automatic test_unknown_ops();
		send_request(FN_RSVD6, '1, '1);
		send_request(FN_RSVD7, '0, '0);
		wait_for_drain();
	endtask

	// One package and one app taken through their whole life.
	task automatic test_app_lifecycle();
		logic [HANDLE_W-1:0] pkg_h;
		logic [HANDLE_W-1:0] app_h;
		send_request(FN_INSTALL, '0, '0);
		pkg_h = last_outcome.new_handle;
		send_request(FN_LAUNCH, pkg_h, '0);
		send_request(FN_LAUNCH, pkg_h, '1);
		app_h = last_outcome.new_handle;
		send_request(FN_PAUSE, app_h, '0);
		send_request(FN_PAUSE, app_h, '1);
		send_request(FN_RESUME, app_h, '0);
		send_request(FN_RESUME, app_h, '1);
		// Uninstalling the package leaves the app alive but kills the package handle.
		send_request(FN_UNINSTALL, pkg_h, '0);
		send_request(FN_LAUNCH, pkg_h, 64'd1);
		send_request(FN_PAUSE, app_h, '0);
		send_request(FN_STOP, app_h, '0);
		send_request(FN_RESUME, app_h, '0);
		wait_for_drain();
	endtask

	// Handles with slot zero, slot past the end, zero generation and all-ones fields.
	task automatic test_bad_handles();
		send_request(FN_UNINSTALL, {GEN_W'(1), SLOT_W'(0)}, '0);
		send_request(FN_PAUSE, {GEN_W'(1), SLOT_W'(NUM_SLOTS + 1)}, '0);
		send_request(FN_UNINSTALL, {GEN_W'(0), SLOT_W'(1)}, '0);
		send_request(FN_STOP, '1, '1);
		send_request(FN_RESUME, {GEN_MAX, SLOT_W'(1)}, '0);
		wait_for_drain();
	endtask

	// Fills both tables past capacity, then frees every other slot.
	task automatic test_table_full();
		logic [HANDLE_W-1:0] pkg_h;
		int                  i;
		for (i = 0; i <= NUM_SLOTS; i++) begin
			send_request(FN_INSTALL, pick_handle(TBL_PKG), {$urandom(), $urandom()});
		end
		pkg_h = make_handle(slot_gen[TBL_PKG][0], 0);
		for (i = 0; i <= NUM_SLOTS; i++) begin
			send_request(FN_LAUNCH, pkg_h, {$urandom(), $urandom()} | 64'd1);
		end
		for (i = 0; i < NUM_SLOTS; i += 2) begin
			send_request(FN_STOP, make_handle(slot_gen[TBL_APP][i], i), '0);
			send_request(FN_UNINSTALL, make_handle(slot_gen[TBL_PKG][i], i), '0);
		end
		wait_for_drain();
	endtask

	// Random mix of operations, mostly on live handles.
	task automatic test_random_traffic(input int unsigned n_items, input bit no_idle);
		int unsigned         k;
		int unsigned         r;
		logic [2:0]          f;
		logic [HANDLE_W-1:0] h;
		logic [63:0]         o;
		quiet_mode = no_idle;
		for (k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 14) f = FN_INSTALL;
			else if (r < 24) f = FN_UNINSTALL;
			else if (r < 46) f = FN_LAUNCH;
			else if (r < 64) f = FN_PAUSE;
			else if (r < 80) f = FN_RESUME;
			else if (r < 93) f = FN_STOP;
			else if (r < 97) f = FN_RSVD6;
			else f = FN_RSVD7;
			h = pick_handle((f == FN_UNINSTALL || f == FN_LAUNCH) ? TBL_PKG : TBL_APP);
			o = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom(), $urandom()};
			send_request(f, h, o);
		end
		wait_for_drain();
		quiet_mode = 1'b0;
	endtask

	// Random back-pressure on the result side.
	always @(posedge clk) begin
		if (quiet_mode) begin
			out_stall  <= 1'b0;
			stall_hold = 0;
		end else if (stall_hold != 0) begin
			stall_hold = stall_hold - 1;
		end else begin
			out_stall  <= ($urandom_range(0, 99) < 35);
			stall_hold = pick_gap();
		end
	end

	// Compares each result taken from the block with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status=%0b handle=0x%0h state=%0d",
					$time, status, new_handle, app_state_after);
				n_errors++;
			end else begin
				next_expected = expected_results.pop_front();
				compare_field("status", HANDLE_W'(next_expected.status), HANDLE_W'(status));
				compare_field("new_handle", next_expected.new_handle, new_handle);
				compare_field("app_state_after", HANDLE_W'(next_expected.state_after),
					HANDLE_W'(app_state_after));
			end
		end
	end

	// Ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("generational_handle_table_top regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			slot_used[TBL_PKG][i] = 1'b0;
			slot_used[TBL_APP][i] = 1'b0;
			slot_gen[TBL_PKG][i]  = '0;
			slot_gen[TBL_APP][i]  = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unknown_ops();
		test_app_lifecycle();
		test_bad_handles();
		test_table_full();
		test_random_traffic(130, 1'b0);
		test_random_traffic(80, 1'b1);
		test_random_traffic(170, 1'b0);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("generational_handle_table_top regression: pass");
		end else begin
			$display("generational_handle_table_top regression: fail");
		end
		$finish;
	end

endmodule
